// ===== rtl/c2e_pkg.sv =====
package c2e_pkg;

  localparam logic [11:0] EPOCH_YEAR         = 12'd1970;
  // leaps_through(1969) = 492 - 19 + 4
  localparam logic [19:0] LEAPS_BEFORE_EPOCH = 20'd477;
  localparam logic [19:0] DAYS_PER_YEAR      = 20'd365;
  localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR      = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN       = 17'd60;
  localparam logic [2:0]  EPOCH_WEEKDAY      = 3'd4;

  // floor(n/100) == (n * DIV100_MUL) >> DIV100_SHIFT for every 12-bit n
  localparam logic [24:0] DIV100_MUL         = 25'd5243;
  localparam int          DIV100_SHIFT       = 19;

  localparam logic [3:0]  MONTH_JAN          = 4'd1;
  localparam logic [3:0]  MONTH_FEB          = 4'd2;
  localparam logic [3:0]  MONTH_DEC          = 4'd12;

  typedef logic [19:0] day_cnt_t;
  typedef logic [36:0] sec_wide_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/calendar_to_epoch_seconds_top.sv =====
// Calendar date/time to seconds since 1970-01-01 00:00:00 (Gregorian).
// Input channel: in_valid/in_stall with year, month, day, hour, minute,
// second. Output channel: out_valid/out_stall with out_valid_res,
// out_epoch_seconds and out_weekday (Sunday = 0). Bad fields, years before
// 1970 and results above 32 bits give out_valid_res = 0 with zero epoch and
// weekday.
// Five register stages (s1, s2, s3, s4, output); a word accepted into s1
// moves through s2, s3 and s4 to the output register, where it waits to be
// taken. One word is accepted per cycle as long as the output is not held;
// the stage boundaries are set by the divide-by-100 multiply, the leap and
// day-of-year math, the day sum, the 20x17 seconds multiply and the final
// overflow/mod-7 step.
// Reset (rst_n low, synchronous) empties all stages; no output is pending.
// While out_valid is high and out_stall is high the whole pipe holds and
// in_stall is raised; the output word stays unchanged until taken.
module calendar_to_epoch_seconds_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic [31:0] out_epoch_seconds,
  output logic [2:0]  out_weekday
);

  logic adv;

  // stage valid bits
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;

  // stage 1
  logic        s1_ok_r;
  logic [11:0] s1_year_r;
  logic [5:0]  s1_q100y_r, s1_q100m_r;
  logic [3:0]  s1_month_r;
  logic [4:0]  s1_day_r;
  logic [16:0] s1_hms_r;

  // stage 2
  logic                 s2_ok_r;
  c2e_pkg::day_cnt_t    s2_days_yr_r;
  logic [8:0]           s2_doy_r;
  logic [16:0]          s2_hms_r;

  // stage 3
  logic                 s3_ok_r;
  c2e_pkg::day_cnt_t    s3_days_r;
  logic [20:0]          s3_days4_r;
  logic [16:0]          s3_hms_r;

  // stage 4
  logic                 s4_ok_r;
  c2e_pkg::sec_wide_t   s4_secs_r;
  logic [5:0]           s4_wsum_r;

  // output
  logic        out_res_r;
  logic [31:0] out_secs_r;
  logic [2:0]  out_wday_r;

  // hold everything while the output word waits
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r;
    end
  end

  // ---------------- stage 1: range checks, year/100, time of day
  logic        s1_ok_nxt;
  logic [11:0] ym1;
  logic [24:0] prod_y, prod_m;
  logic [16:0] hms_nxt;

  always_comb begin
    ym1       = in_year - 12'd1;
    prod_y    = 25'(in_year) * c2e_pkg::DIV100_MUL;
    prod_m    = 25'(ym1) * c2e_pkg::DIV100_MUL;
    s1_ok_nxt = (in_year >= c2e_pkg::EPOCH_YEAR) &&
                (in_month >= c2e_pkg::MONTH_JAN) && (in_month <= c2e_pkg::MONTH_DEC) &&
                (in_day != 5'd0) && (in_hour <= 5'd23) &&
                (in_minute <= 6'd59) && (in_second <= 6'd59);
    hms_nxt   = 17'(in_hour) * c2e_pkg::SECS_PER_HOUR +
                17'(in_minute) * c2e_pkg::SECS_PER_MIN + 17'(in_second);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ok_r    <= s1_ok_nxt;
      s1_year_r  <= in_year;
      s1_q100y_r <= prod_y[c2e_pkg::DIV100_SHIFT +: 6];
      s1_q100m_r <= prod_m[c2e_pkg::DIV100_SHIFT +: 6];
      s1_month_r <= in_month;
      s1_day_r   <= in_day;
      s1_hms_r   <= hms_nxt;
    end
  end

  // ---------------- stage 2: leap year, days before year, day of year
  logic [11:0]       s1_ym1;
  logic [11:0]       r100;
  logic              leap;
  logic [19:0]       leaps;
  c2e_pkg::day_cnt_t days_yr_nxt;
  logic [8:0]        doy_nxt;
  logic              day_ok;

  always_comb begin
    s1_ym1 = s1_year_r - 12'd1;
    r100   = s1_year_r - 12'(s1_q100y_r) * 12'd100;
    leap   = (s1_year_r[1:0] == 2'd0) && ((r100 != 12'd0) || (s1_q100y_r[1:0] == 2'd0));
    // leaps in 1970..year-1: n/4 - n/100 + n/400 with n = year-1, minus the epoch's count
    leaps  = 20'(s1_ym1[11:2]) - 20'(s1_q100m_r) + 20'(s1_q100m_r[5:2]) -
             c2e_pkg::LEAPS_BEFORE_EPOCH;
    days_yr_nxt = c2e_pkg::DAYS_PER_YEAR * 20'(s1_year_r - c2e_pkg::EPOCH_YEAR) + leaps;
    day_ok  = s1_day_r <= c2e_pkg::month_len(s1_month_r, leap);
    doy_nxt = c2e_pkg::days_before_month(s1_month_r) +
              9'((s1_month_r > c2e_pkg::MONTH_FEB) && leap) + 9'(s1_day_r) - 9'd1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ok_r      <= s1_ok_r && day_ok;
      s2_days_yr_r <= days_yr_nxt;
      s2_doy_r     <= doy_nxt;
      s2_hms_r     <= s1_hms_r;
    end
  end

  // ---------------- stage 3: total days
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ok_r    <= s2_ok_r;
      s3_days_r  <= s2_days_yr_r + 20'(s2_doy_r);
      s3_days4_r <= 21'(s2_days_yr_r) + 21'(s2_doy_r) + 21'(c2e_pkg::EPOCH_WEEKDAY);
      s3_hms_r   <= s2_hms_r;
    end
  end

  // ---------------- stage 4: seconds, octal digit sum for mod 7
  c2e_pkg::sec_wide_t secs_nxt;
  logic [5:0]         wsum_nxt;

  always_comb begin
    secs_nxt = 37'(s3_days_r) * 37'(c2e_pkg::SECS_PER_DAY) + 37'(s3_hms_r);
    // 8 == 1 mod 7, so the octal digit sum keeps the residue
    wsum_nxt = 6'd0;
    for (int i = 0; i < 7; i++) begin
      wsum_nxt = wsum_nxt + 6'(s3_days4_r[3*i +: 3]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ok_r   <= s3_ok_r;
      s4_secs_r <= secs_nxt;
      s4_wsum_r <= wsum_nxt;
    end
  end

  // ---------------- stage 5: overflow check, final mod 7, zero when invalid
  logic       res_nxt;
  logic [3:0] w2;
  logic [2:0] wday_nxt;

  always_comb begin
    res_nxt  = s4_ok_r && (s4_secs_r[36:32] == 5'd0);
    w2       = 4'(s4_wsum_r[5:3]) + 4'(s4_wsum_r[2:0]);
    wday_nxt = (w2 >= 4'd7) ? 3'(w2 - 4'd7) : w2[2:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r  <= res_nxt;
      out_secs_r <= res_nxt ? s4_secs_r[31:0] : 32'd0;
      out_wday_r <= res_nxt ? wday_nxt : 3'd0;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_valid_res     = out_res_r;
  assign out_epoch_seconds = out_secs_r;
  assign out_weekday       = out_wday_r;

endmodule
